### design/assert_macros.svh
// Assertion macros shared by the key set table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ukst_pkg.sv
// Package for the key set table: sizes, action codes, payload and control types.
package ukst_pkg;

   localparam int CAPACITY   = 80;
   localparam int KEY_BITS   = 22;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int COUNT_BITS = 7;   // width of the entry_count result field

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic                  refused;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic                do_add;
      logic                do_remove;
      logic [IDX_BITS-1:0] pos;
      logic [CNT_BITS-1:0] count;
      logic [KEY_BITS-1:0] key;
   } cell_ctl_type;

   // Lookup summary from the row of cells
   typedef struct packed {
      logic                hit;
      logic [IDX_BITS-1:0] pos;
   } lookup_type;

endpackage

### design/ukst_cell.sv
// One storage cell: holds a key, compares it, and takes a key from its upper neighbor.
module ukst_cell (
   input  logic                          clock,
   input  logic [ukst_pkg::IDX_BITS-1:0] cell_idx,
   input  ukst_pkg::cell_ctl_type        ctl,
   input  logic                          update_en,
   input  logic [ukst_pkg::KEY_BITS-1:0] key_up,
   output logic [ukst_pkg::KEY_BITS-1:0] key_out,
   output logic                          match
);

   logic [ukst_pkg::KEY_BITS-1:0] key_ff;
   logic [ukst_pkg::KEY_BITS-1:0] key_in;
   logic                          occupied;

   // only slots below the fill count hold live keys
   assign occupied = ukst_pkg::CNT_BITS'(cell_idx) < ctl.count;
   assign match    = occupied && (key_ff == ctl.key);
   assign key_out  = key_ff;

   // shift down on remove at or above the hit slot; append at the fill slot on add
   always_comb begin
      key_in = key_ff;
      if (update_en) begin
         if (ctl.do_remove && (cell_idx >= ctl.pos)) begin
            key_in = key_up;
         end else if (ctl.do_add && (ukst_pkg::CNT_BITS'(cell_idx) == ctl.count)) begin
            key_in = ctl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

### design/ukst_chain.sv
// Row of key cells with the match reduction and hit position encoder.
module ukst_chain (
   input  logic                          clock,
   input  ukst_pkg::cell_ctl_type        ctl,
   input  logic                          update_en,
   output ukst_pkg::lookup_type          lookup,
   output logic [ukst_pkg::CAPACITY-1:0] match_vec
);

   logic [ukst_pkg::KEY_BITS-1:0] cell_key [ukst_pkg::CAPACITY];

   // each cell takes its upper neighbor's key; the top cell recirculates its own
   for (genvar i = 0; i < ukst_pkg::CAPACITY; i++) begin : g_cell
      logic [ukst_pkg::KEY_BITS-1:0] key_up;
      if (i == ukst_pkg::CAPACITY - 1) begin : g_top
         assign key_up = cell_key[i];
      end else begin : g_mid
         assign key_up = cell_key[i+1];
      end

      ukst_cell u_cell (
         .clock     (clock),
         .cell_idx  (ukst_pkg::IDX_BITS'(i)),
         .ctl       (ctl),
         .update_en (update_en),
         .key_up    (key_up),
         .key_out   (cell_key[i]),
         .match     (match_vec[i])
      );
   end

   // keys are unique, so at most one match: OR the indices together
   always_comb begin
      lookup.hit = |match_vec;
      lookup.pos = '0;
      for (int i = 0; i < ukst_pkg::CAPACITY; i++) begin
         if (match_vec[i]) begin
            lookup.pos = lookup.pos | ukst_pkg::IDX_BITS'(i);
         end
      end
   end

endmodule

### design/unique_key_set_table.sv
// Top level of the key set table: controller, fill count and response register.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | req_data   (action, key)
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_data   (hit, refused, entry_count)
//
// Each transaction has a match step, which compares the key against all cells
// at once and encodes the hit slot, and an apply step, which shifts or appends in the cell row.
// The next request is taken in the apply cycle, while the current one is being applied.
// A response waiting in the output register stalls only the apply cycle.
// Synchronous reset clears the fill count and control; cell keys are not reset.
`include "assert_macros.svh"

module unique_key_set_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ukst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ukst_pkg::rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                    state_ff, state_in;
   ukst_pkg::req_type             op_ff, op_in;
   logic [ukst_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                          hit_ff, hit_in;
   logic [ukst_pkg::IDX_BITS-1:0] pos_ff, pos_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ukst_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   ukst_pkg::cell_ctl_type        ctl;
   ukst_pkg::lookup_type          lookup;
   logic [ukst_pkg::CAPACITY-1:0] match_vec;
   logic                          req_fire;
   logic                          apply_fire;
   logic                          full;
   logic                          is_add;
   logic                          is_remove;

   assign full       = count_ff == ukst_pkg::CNT_BITS'(ukst_pkg::CAPACITY);
   assign is_add     = op_ff.action == ukst_pkg::ACT_ADD;
   assign is_remove  = op_ff.action == ukst_pkg::ACT_REMOVE;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == S_IDLE) || apply_fire;
   assign req_fire   = req_valid && req_ready;

   // broadcast to the cell row
   always_comb begin
      ctl.do_add    = is_add && !hit_ff && !full;
      ctl.do_remove = is_remove && hit_ff;
      ctl.pos       = pos_ff;
      ctl.count     = count_ff;
      ctl.key       = op_ff.key;
   end

   ukst_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .update_en (apply_fire),
      .lookup    (lookup),
      .match_vec (match_vec)
   );

   // sequencer, lookup capture and fill count
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      hit_in   = hit_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            hit_in   = lookup.hit;
            pos_in   = lookup.pos;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) begin
               if (ctl.do_add) begin
                  count_in = count_ff + 1'b1;
               end else if (ctl.do_remove) begin
                  count_in = count_ff - 1'b1;
               end
               state_in = req_fire ? S_MATCH : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (req_fire) begin
         op_in = req_data;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (apply_fire) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.hit         = hit_ff;
         rsp_data_in.refused     = is_add && !hit_ff && full;
         rsp_data_in.entry_count = ukst_pkg::COUNT_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `ASSERT_IMPL(a_unique_match, clock, reset, state_ff == S_MATCH, $countones(match_vec) <= 1, "more than one cell matched the key")
   `ASSERT_IMPL(a_refused_full, clock, reset, rsp_valid && rsp_data.refused, rsp_data.entry_count == ukst_pkg::COUNT_BITS'(ukst_pkg::CAPACITY), "refused add with table not full")
   `ASSERT_NEXT(a_remove_count, clock, reset, apply_fire && ctl.do_remove, count_ff == $past(count_ff) - 1'b1, "remove hit did not drop the fill count")
   `ASSERT_NEXT(a_accept_match, clock, reset, req_fire, state_ff == S_MATCH, "accepted transaction did not enter lookup")

endmodule

### tb/tb_unique_key_set_table.sv
// Self-checking testbench for the key set table: directed table, then random episodes.
module tb_unique_key_set_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;   // undefined code, acts as a query
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_CYCLES  = 200;
   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int CALM_LO      = 250;          // window with no idling on either side
   localparam int CALM_HI      = 350;

   typedef enum {EP_GROW, EP_SHRINK, EP_CHURN, EP_FILL} episode_kind_type;

   typedef struct packed {
      ukst_pkg::req_type op;
      logic              known;
      ukst_pkg::rsp_type want;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ukst_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ukst_pkg::rsp_type rsp_data;

   // Shadow copy of the table
   logic [ukst_pkg::KEY_BITS-1:0] shadow_keys [ukst_pkg::CAPACITY];
   int                            shadow_count = 0;
   ukst_pkg::rsp_type             key_results_due [$];

   int fail_count = 0;
   int rsp_seen   = 0;
   int sent_count = 0;

   // Directed walk; last field is the typed-in result where it is obvious
   directed_row_type directed_rows [24] = '{
      '{'{ukst_pkg::ACT_QUERY,  22'h000000}, 1'b1, '{1'b0, 1'b0, 7'd0}},  // empty table
      '{'{ukst_pkg::ACT_REMOVE, 22'h000005}, 1'b1, '{1'b0, 1'b0, 7'd0}},  // remove from empty
      '{'{ukst_pkg::ACT_ADD,    22'h000000}, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{'{ukst_pkg::ACT_ADD,    22'h3FFFFF}, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{'{ukst_pkg::ACT_ADD,    22'h000000}, 1'b1, '{1'b1, 1'b0, 7'd2}},  // duplicate add
      '{'{ukst_pkg::ACT_QUERY,  22'h3FFFFF}, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{'{ACT_UNUSED,           22'h000000}, 1'b1, '{1'b1, 1'b0, 7'd2}},  // unused, present
      '{'{ACT_UNUSED,           22'h000123}, 1'b1, '{1'b0, 1'b0, 7'd2}},  // unused, absent
      '{'{ukst_pkg::ACT_ADD,    22'h2AAAAA}, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{'{ukst_pkg::ACT_ADD,    22'h155555}, 1'b1, '{1'b0, 1'b0, 7'd4}},
      '{'{ukst_pkg::ACT_REMOVE, 22'h3FFFFF}, 1'b1, '{1'b1, 1'b0, 7'd3}},  // middle remove
      '{'{ukst_pkg::ACT_QUERY,  22'h3FFFFF}, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{'{ukst_pkg::ACT_QUERY,  22'h155555}, 1'b1, '{1'b1, 1'b0, 7'd3}},  // entry moved down
      '{'{ukst_pkg::ACT_REMOVE, 22'h3FFFFF}, 1'b1, '{1'b0, 1'b0, 7'd3}},  // remove absent
      '{'{ukst_pkg::ACT_ADD,    22'h3FFFFF}, 1'b1, '{1'b0, 1'b0, 7'd4}},
      '{'{ukst_pkg::ACT_REMOVE, 22'h000000}, 1'b1, '{1'b1, 1'b0, 7'd3}},  // first entry
      '{'{ukst_pkg::ACT_REMOVE, 22'h3FFFFF}, 1'b1, '{1'b1, 1'b0, 7'd2}},  // last entry
      '{'{ukst_pkg::ACT_ADD,    22'h000001}, 1'b0, '0},
      '{'{ukst_pkg::ACT_QUERY,  22'h155555}, 1'b0, '0},
      '{'{ukst_pkg::ACT_REMOVE, 22'h2AAAAA}, 1'b0, '0},
      '{'{ukst_pkg::ACT_ADD,    22'h000000}, 1'b0, '0},
      '{'{ukst_pkg::ACT_REMOVE, 22'h155555}, 1'b0, '0},
      '{'{ukst_pkg::ACT_REMOVE, 22'h000001}, 1'b0, '0},
      '{'{ukst_pkg::ACT_REMOVE, 22'h000000}, 1'b0, '0}
   };

   unique_key_set_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   // Position of the first stored copy of a key, -1 if absent
   function automatic int find_key(logic [ukst_pkg::KEY_BITS-1:0] k);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_keys[i] == k) return i;
      end
      return -1;
   endfunction

   // Apply one transaction to the shadow table and return its result
   function automatic ukst_pkg::rsp_type apply_key_op(ukst_pkg::req_type op);
      ukst_pkg::rsp_type res;
      int                pos;
      pos = find_key(op.key);
      res.hit = (pos >= 0);
      res.refused = 1'b0;
      if (op.action == ukst_pkg::ACT_ADD) begin
         if (pos < 0) begin
            if (shadow_count < ukst_pkg::CAPACITY) begin
               shadow_keys[shadow_count] = op.key;
               shadow_count++;
            end else begin
               res.refused = 1'b1;
            end
         end
      end else if (op.action == ukst_pkg::ACT_REMOVE) begin
         if (pos >= 0) begin
            // close the gap so the list stays packed
            for (int j = pos; j < shadow_count - 1; j++) shadow_keys[j] = shadow_keys[j + 1];
            shadow_count--;
         end
      end
      res.entry_count = ukst_pkg::COUNT_BITS'(shadow_count);
      return res;
   endfunction

   // Key not currently stored; sometimes one of the extremes
   function automatic logic [ukst_pkg::KEY_BITS-1:0] fresh_key();
      logic [ukst_pkg::KEY_BITS-1:0] k;
      int                            pick;
      pick = $urandom_range(0, 19);
      k = (pick == 0) ? '0 : (pick == 1) ? '1 : ukst_pkg::KEY_BITS'($urandom);
      while (find_key(k) >= 0) k = ukst_pkg::KEY_BITS'($urandom);
      return k;
   endfunction

   function automatic logic [ukst_pkg::KEY_BITS-1:0] stored_key();
      if (shadow_count == 0) return fresh_key();
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
   endfunction

   // Offer one transaction; called and returns just after a falling edge
   task automatic send_op(ukst_pkg::req_type op, logic known, ukst_pkg::rsp_type want);
      ukst_pkg::rsp_type res;
      while (!(sent_count >= CALM_LO && sent_count < CALM_HI) &&
             $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (!req_ready);
      res = apply_key_op(op);
      key_results_due.push_back(known ? want : res);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic issue(logic [1:0] act, logic [ukst_pkg::KEY_BITS-1:0] k);
      ukst_pkg::req_type op;
      op.action = act;
      op.key = k;
      send_op(op, 1'b0, '0);
   endtask

   // Stop offering until every outstanding result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (key_results_due.size() != 0) @(negedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      ukst_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (key_results_due.size() == 0) begin
            $error("unexpected transaction on result channel: %p", rsp_data);
            fail_count++;
         end else begin
            want = key_results_due.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
               fail_count++;
            end
            if (rsp_data.refused !== want.refused) begin
               $error("refused: expected %0d, got %0d", want.refused, rsp_data.refused);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Result receiver: random back-pressure plus two long hold-offs
   initial begin
      int hold_at;
      hold_at = 150;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_seen >= hold_at) begin
            hold_at = (hold_at < 450) ? 450 : 32'h7FFF_FFFF;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= (rsp_seen >= CALM_LO && rsp_seen < CALM_HI) ||
                         ($urandom_range(0, 99) >= 37);
            @(negedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      episode_kind_type kind;
      int               pick;
      int               episode;
      int               last_item;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_op(directed_rows[i].op, directed_rows[i].known, directed_rows[i].want);
      wait_drained();

      last_item = sent_count + RANDOM_ITEMS;
      episode = 0;
      while (sent_count < last_item) begin
         kind = (episode == 0 || episode == 7) ? EP_FILL :
                episode_kind_type'($urandom_range(0, 3));
         if (episode == 4) wait_drained();
         case (kind)
            EP_GROW: begin
               repeat (40) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 70) issue(ukst_pkg::ACT_ADD, fresh_key());
                  else if (pick < 85) issue(ukst_pkg::ACT_ADD, stored_key());
                  else issue(ukst_pkg::ACT_QUERY,
                             $urandom_range(0, 1) ? stored_key() : fresh_key());
               end
            end
            EP_SHRINK: begin
               repeat (30) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 60) issue(ukst_pkg::ACT_REMOVE, stored_key());
                  else if (pick < 80) issue(ukst_pkg::ACT_REMOVE, fresh_key());
                  else issue(ukst_pkg::ACT_QUERY, stored_key());
               end
            end
            EP_CHURN: begin
               // loosely formed noise, any code and any key
               repeat (40)
                  issue(2'($urandom_range(0, 3)),
                        $urandom_range(0, 1) ? stored_key() : ukst_pkg::KEY_BITS'($urandom));
            end
            default: begin
               // fill to capacity, then push on the full table
               while (shadow_count < ukst_pkg::CAPACITY) issue(ukst_pkg::ACT_ADD, fresh_key());
               repeat (20) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 45) issue(ukst_pkg::ACT_ADD, fresh_key());
                  else if (pick < 60) issue(ukst_pkg::ACT_ADD, stored_key());
                  else if (pick < 75) issue(ukst_pkg::ACT_REMOVE, stored_key());
                  else if (pick < 88) issue(ukst_pkg::ACT_QUERY, fresh_key());
                  else issue(ACT_UNUSED, stored_key());
               end
            end
         endcase
         episode++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### unique_key_set_table.f
+incdir+design
design/ukst_pkg.sv
design/ukst_cell.sv
design/ukst_chain.sv
design/unique_key_set_table.sv
tb/tb_unique_key_set_table.sv
